// ===== hdl/b64d_pkg.sv =====
// b64d_pkg: shared types, constants and the character classifier for the base64 decoder
// no dependencies; used by every module of the decoder by scoped names
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int unsigned SEXTET_W = 6;
	localparam int unsigned ACC_W    = 18;
	localparam int unsigned GROUP_W  = 24;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_PAD   = 8'h3d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
	localparam logic [7:0] CHAR_DIG_0 = 8'h30;
	localparam logic [7:0] CHAR_DIG_9 = 8'h39;

	localparam logic [5:0] SEXTET_LC_BASE  = 6'd26;
	localparam logic [5:0] SEXTET_DIG_BASE = 6'd52;
	localparam logic [5:0] SEXTET_PLUS     = 6'd62;
	localparam logic [5:0] SEXTET_SLASH    = 6'd63;

	typedef enum logic [1:0] {
		CLS_BLANK  = 2'd0,
		CLS_SEXTET = 2'd1,
		CLS_TERM   = 2'd2,
		CLS_BAD    = 2'd3
	} char_class_t;

	typedef struct packed {
		char_class_t      cls;
		logic [SEXTET_W-1:0] sextet;
	} char_info_t;

	// one unit of work handed from the front to the back
	typedef struct packed {
		logic [GROUP_W-1:0] bytes;     // first byte in the top octet
		logic               has_data;  // zero means a single beat with no byte
		logic [1:0]         extra;     // beats after the first
		logic               ends;
		logic               bad;
	} job_t;

	function automatic char_info_t classify(input logic [7:0] c);
		char_info_t info;
		info.cls    = CLS_BAD;
		info.sextet = '0;
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
			info.cls    = CLS_SEXTET;
			info.sextet = 6'(c - CHAR_UC_A);
		end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			info.cls    = CLS_SEXTET;
			info.sextet = 6'(c - CHAR_LC_A) + SEXTET_LC_BASE;
		end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
			info.cls    = CLS_SEXTET;
			info.sextet = 6'(c - CHAR_DIG_0) + SEXTET_DIG_BASE;
		end else if (c == CHAR_PLUS) begin
			info.cls    = CLS_SEXTET;
			info.sextet = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			info.cls    = CLS_SEXTET;
			info.sextet = SEXTET_SLASH;
		end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
			info.cls = CLS_BLANK;
		end else if (c == CHAR_NUL || c == CHAR_PAD) begin
			info.cls = CLS_TERM;
		end
		return info;
	endfunction

endpackage

// ===== hdl/b64d_front.sv =====
// b64d_front: takes accepted characters, classifies them and gathers sextets into jobs
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_code,
	output logic              job_wr,
	output b64d_pkg::job_t    job
);

	logic [b64d_pkg::ACC_W-1:0] acc_q;
	logic [1:0]                 cnt_q;
	b64d_pkg::char_info_t       info;
	logic [b64d_pkg::GROUP_W-1:0] full_group;

	assign info       = b64d_pkg::classify(char_code);
	assign full_group = {acc_q, info.sextet};

	always_comb begin
		job_wr       = 1'b0;
		job.bytes    = '0;
		job.has_data = 1'b0;
		job.extra    = 2'd0;
		job.ends     = 1'b0;
		job.bad      = 1'b0;
		unique case (info.cls)
			b64d_pkg::CLS_BLANK: begin
			end
			b64d_pkg::CLS_SEXTET: begin
				if (cnt_q == 2'd3) begin
					job_wr       = accept;
					job.bytes    = full_group;
					job.has_data = 1'b1;
					job.extra    = 2'd2;
				end
			end
			b64d_pkg::CLS_TERM, b64d_pkg::CLS_BAD: begin
				job_wr   = accept;
				job.ends = 1'b1;
				job.bad  = (info.cls == b64d_pkg::CLS_BAD);
				unique case (cnt_q)
					2'd2: begin
						job.bytes    = {acc_q[11:4], 16'h0000};
						job.has_data = 1'b1;
					end
					2'd3: begin
						job.bytes    = {acc_q[17:10], acc_q[9:2], 8'h00};
						job.has_data = 1'b1;
						job.extra    = 2'd1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= 2'd0;
		end else if (accept) begin
			if (info.cls == b64d_pkg::CLS_SEXTET && cnt_q != 2'd3) begin
				acc_q <= {acc_q[11:0], info.sextet};
				cnt_q <= cnt_q + 2'd1;
			end else if (info.cls != b64d_pkg::CLS_BLANK) begin
				acc_q <= '0;
				cnt_q <= 2'd0;
			end
		end
	end

endmodule

// ===== hdl/b64d_job_fifo.sv =====
// b64d_job_fifo: short queue of jobs between the front and the back
// depends on b64d_pkg for the job type
`timescale 1ns / 1ps

module b64d_job_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  b64d_pkg::job_t wr_job,
	input  logic           rd,
	output b64d_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64d_pkg::job_t   slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/b64d_back.sv =====
// b64d_back: expands each job into one to three result beats held in an output register
// depends on b64d_pkg for the job type
`timescale 1ns / 1ps

module b64d_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_avail,
	input  b64d_pkg::job_t job,
	output logic           job_rd,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     data_byte,
	output logic           byte_valid,
	output logic           run_last,
	output logic           stream_end,
	output logic           bad_char
);

	logic                         busy_q;
	logic [b64d_pkg::GROUP_W-1:0] bytes_q;
	logic                         has_data_q;
	logic [1:0]                   rem_q;
	logic                         ends_q;
	logic                         bad_q;
	logic                         last;

	assign last   = (rem_q == 2'd0);
	assign empty  = !busy_q;
	assign job_rd = job_avail && (!busy_q || (pop && last));

	assign data_byte  = has_data_q ? bytes_q[23:16] : 8'h00;
	assign byte_valid = has_data_q;
	assign run_last   = last;
	assign stream_end = last && ends_q;
	assign bad_char   = last && bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= 2'd0;
		end else if (job_rd) begin
			busy_q <= 1'b1;
			rem_q  <= job.extra;
		end else if (pop && busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rem_q <= rem_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_rd) begin
			bytes_q    <= job.bytes;
			has_data_q <= job.has_data;
			ends_q     <= job.ends;
			bad_q      <= job.bad;
		end else if (pop && busy_q && !last) begin
			bytes_q <= {bytes_q[15:0], 8'h00};
		end
	end

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// base64_stream_decoder: top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_front, b64d_job_fifo and b64d_back
`timescale 1ns / 1ps

// usage
//   input side: one character per beat on char_code, taken when push is high and full low
//   output side: the oldest result sits on the result ports while empty is low and
//   leaves when pop is high; each character gives zero to three result beats
//   blanks give no beat; the fourth sextet of a group gives three byte beats;
//   '=', nul or a bad character flushes the open group and flags the last beat
// timing
//   one character a cycle, back to back, while full is low; the front updates the
//   sextet accumulator in the cycle of the beat; a character's first result passes
//   through the job queue and then the output register; the back drains one result
//   beat a cycle while pop is high; since four characters at most make three bytes,
//   the output side keeps up with a steady input of one per cycle
// stalls
//   while pop stays low the job queue fills; full rises once QUEUE_DEPTH jobs wait,
//   blanks and sextets that only extend a group still need a free slot to be taken
// reset
//   arst_n clears the accumulator, the queue pointers and the busy flag of the
//   output register; the block is ready for a new stream as soon as reset is released

module base64_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       stream_end,
	output logic       bad_char
);

	// handshake on the character side
	logic           accept;
	// job from the front into the queue
	logic           job_wr;
	b64d_pkg::job_t front_job;
	// queue head towards the back
	b64d_pkg::job_t head_job;
	logic           q_empty;
	logic           job_rd;

	assign accept = push && !full;

	// front: classify, collect sextets, issue a job at group or stream end
	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.job_wr    (job_wr),
		.job       (front_job)
	);

	// decoupling queue, lets the output side stall without stopping the front at once
	b64d_job_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wr_job (front_job),
		.rd     (job_rd),
		.rd_job (head_job),
		.full   (full),
		.empty  (q_empty)
	);

	// back: one result beat a cycle from the head job while pop is high, held until popped
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_avail  (!q_empty),
		.job        (head_job),
		.job_rd     (job_rd),
		.pop        (pop),
		.empty      (empty),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.stream_end (stream_end),
		.bad_char   (bad_char)
	);

`ifndef NO_ASSERTIONS
	// the queue is never written while it is full
	assert property (@(posedge clk) disable iff (!arst_n) job_wr |-> !full)
		else $error("job written into a full queue");

	// a stalled result beat keeps its byte, run_last and stream_end
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(run_last)
			&& $stable(stream_end)))
		else $error("result beat changed while stalled");

	// the error flag comes only on the closing beat of a stream
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && bad_char) |-> (stream_end && run_last))
		else $error("bad_char without stream end");

	// only the closing beat of a character may carry no byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !run_last) |-> byte_valid)
		else $error("byte-less beat before the last one");
`endif

endmodule
